@@ rtl/bmp_stream_pixel_decoder_macros.svh @@
// assertion macros for the bmp stream pixel decoder
`ifndef BMP_STREAM_PIXEL_DECODER_MACROS_SVH
`define BMP_STREAM_PIXEL_DECODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define BMPDEC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define BMPDEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/bmpdec_pkg.sv @@
// shared types and constants of the bmp stream pixel decoder
package bmpdec_pkg;

   // default size limits
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   // header layout and checks
   localparam int          HDR_LEN      = 54;
   localparam logic [5:0]  HDR_LAST_IDX = 6'(HDR_LEN - 1);
   localparam logic [15:0] BMP_SIG      = 16'h4D42;
   localparam logic [31:0] MIN_INFO     = 32'd40;
   localparam logic [31:0] MIN_OFFSET   = 32'(HDR_LEN);
   localparam logic [15:0] ONE_PLANE    = 16'd1;
   localparam logic [15:0] BPP_24       = 16'd24;
   localparam logic [15:0] BPP_32       = 16'd32;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

   // outcome codes
   localparam logic [1:0] OUT_BUSY  = 2'd0;
   localparam logic [1:0] OUT_DONE  = 2'd1;
   localparam logic [1:0] OUT_ERROR = 2'd2;

   // error codes
   localparam logic [3:0] ERR_NONE  = 4'd0;
   localparam logic [3:0] ERR_SIG   = 4'd1;
   localparam logic [3:0] ERR_INFO  = 4'd2;
   localparam logic [3:0] ERR_PLANE = 4'd3;
   localparam logic [3:0] ERR_BPP   = 4'd4;
   localparam logic [3:0] ERR_COMP  = 4'd5;
   localparam logic [3:0] ERR_DIM   = 4'd6;
   localparam logic [3:0] ERR_OFFS  = 4'd7;
   localparam logic [3:0] ERR_TRUNC = 4'd8;

   // parse phases, one-hot
   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_HEADER = 6'b000010,
      PH_SKIP   = 6'b000100,
      PH_PIXELS = 6'b001000,
      PH_DONE   = 6'b010000,
      PH_ERROR  = 6'b100000
   } phase_type;

   // input word
   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_type;

   // result word
   typedef struct packed {
      logic        has_pixel;
      logic [31:0] pixel_argb;
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic [1:0]  outcome;
      logic [3:0]  error_code;
      logic [12:0] image_width;
      logic [12:0] image_height;
   } rsp_type;

endpackage

@@ rtl/bmp_stream_pixel_decoder.sv @@
// bmp stream pixel decoder: header parse, offset skip, pixel assembly
// The result word of an accepted byte is registered in the output register.
// Throughput: one byte per cycle unless a held result word is stalled at the output.
// A result word appears for a pixel, image completion or an error; other bytes give none.
// Reset (synchronous, active high) returns the parser to idle and empties the output.
// first_byte restarts parsing at any time; bytes outside a file are dropped.
`include "bmp_stream_pixel_decoder_macros.svh"

module bmp_stream_pixel_decoder #(
   parameter int MAX_WIDTH  = bmpdec_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bmpdec_pkg::DEF_MAX_HEIGHT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bmpdec_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bmpdec_pkg::rsp_type rsp_data
);

   // counter widths follow the size limits
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int RW = $clog2(4 * MAX_WIDTH + 1);

   // header byte positions of the fields
   localparam logic [5:0] POS_SIG_END   = 6'd1;
   localparam logic [5:0] POS_OFF       = 6'd10;
   localparam logic [5:0] POS_INFO      = 6'd14;
   localparam logic [5:0] POS_WIDTH     = 6'd18;
   localparam logic [5:0] POS_HEIGHT    = 6'd22;
   localparam logic [5:0] POS_PLANES    = 6'd26;
   localparam logic [5:0] POS_BPP       = 6'd28;
   localparam logic [5:0] POS_COMP      = 6'd30;
   localparam logic [5:0] POS_FIELD_END = 6'd34;

   // state
   bmpdec_pkg::phase_type phase_ff, phase_in;
   logic [31:0]           pos_ff, pos_in;
   logic [15:0]           sig_ff, sig_in;
   logic [31:0]           off_ff, off_in;
   logic [31:0]           info_ff, info_in;
   logic [31:0]           wraw_ff, wraw_in;
   logic [31:0]           hraw_ff, hraw_in;
   logic [15:0]           planes_ff, planes_in;
   logic [15:0]           bpp_ff, bpp_in;
   logic [31:0]           comp_ff, comp_in;
   logic [31:0]           pix_off_ff, pix_off_in;
   logic [WW-1:0]         img_w_ff, img_w_in;
   logic [HW-1:0]         img_h_ff, img_h_in;
   logic [RW-1:0]         row_total_ff, row_total_in;
   logic [RW-1:0]         bir_ff, bir_in;
   logic [WW-1:0]         x_ff, x_in;
   logic [1:0]            k_ff, k_in;
   logic [HW-1:0]         rows_ff, rows_in;
   logic [15:0]           partial_ff, partial_in;
   logic                  bottom_ff, bottom_in;
   logic                  four_ff, four_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   bmpdec_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // step signals
   logic          accept;
   logic          event_hit;
   logic          pix_hit;
   logic [31:0]   argb;
   logic [WW-1:0] px;
   logic [HW-1:0] py;
   logic [3:0]    err_code;
   logic [31:0]   idx;
   logic [5:0]    idx6;
   logic [1:0]    lane;
   logic [1:0]    k_last;
   logic [RW:0]   bir_next;
   logic [HW:0]   rows_next;

   // header checks
   logic [31:0]   habs;
   logic          w_bad;
   logic          h_bad;
   logic [3:0]    hdr_err;
   logic [RW-1:0] w_row;
   logic [RW-1:0] row_calc;
   logic [WW-1:0] w_trunc;
   logic [HW-1:0] h_trunc;

   // widened views for the output fields
   logic [31:0]   px_ext;
   logic [31:0]   py_ext;
   logic [31:0]   w_ext;
   logic [31:0]   h_ext;

   // terms for the checks
   logic          chk_err_ok;
   logic          chk_in_pix;
   logic          chk_col_ok;
   logic          chk_restart;
   logic          chk_hdr_or_err;

   // output side
   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // header field checks, evaluated from the captured fields
   assign habs    = hraw_ff[31] ? (~hraw_ff + 32'd1) : hraw_ff;
   assign w_bad   = (wraw_ff == 32'd0) || wraw_ff[31] || (wraw_ff > 32'(MAX_WIDTH));
   assign h_bad   = (habs == 32'd0) || (habs > 32'(MAX_HEIGHT));
   assign w_trunc = wraw_ff[WW-1:0];
   assign h_trunc = habs[HW-1:0];

   always_comb begin
      if (sig_ff != bmpdec_pkg::BMP_SIG) begin
         hdr_err = bmpdec_pkg::ERR_SIG;
      end else if (info_ff < bmpdec_pkg::MIN_INFO) begin
         hdr_err = bmpdec_pkg::ERR_INFO;
      end else if (planes_ff != bmpdec_pkg::ONE_PLANE) begin
         hdr_err = bmpdec_pkg::ERR_PLANE;
      end else if (bpp_ff != bmpdec_pkg::BPP_24 && bpp_ff != bmpdec_pkg::BPP_32) begin
         hdr_err = bmpdec_pkg::ERR_BPP;
      end else if (comp_ff != 32'd0) begin
         hdr_err = bmpdec_pkg::ERR_COMP;
      end else if (w_bad || h_bad) begin
         hdr_err = bmpdec_pkg::ERR_DIM;
      end else if (off_ff < bmpdec_pkg::MIN_OFFSET) begin
         hdr_err = bmpdec_pkg::ERR_OFFS;
      end else begin
         hdr_err = bmpdec_pkg::ERR_NONE;
      end
   end

   // row length in bytes, padded to a multiple of four
   assign w_row    = RW'(w_trunc);
   assign row_calc = (bpp_ff == bmpdec_pkg::BPP_32) ? (w_row << 2)
                   : (((w_row << 1) + w_row + RW'(3)) & ~RW'(3));

   // last byte index within a pixel
   assign k_last = four_ff ? 2'd3 : 2'd2;

   // per-byte parse step
   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      sig_in       = sig_ff;
      off_in       = off_ff;
      info_in      = info_ff;
      wraw_in      = wraw_ff;
      hraw_in      = hraw_ff;
      planes_in    = planes_ff;
      bpp_in       = bpp_ff;
      comp_in      = comp_ff;
      pix_off_in   = pix_off_ff;
      img_w_in     = img_w_ff;
      img_h_in     = img_h_ff;
      row_total_in = row_total_ff;
      bir_in       = bir_ff;
      x_in         = x_ff;
      k_in         = k_ff;
      rows_in      = rows_ff;
      partial_in   = partial_ff;
      bottom_in    = bottom_ff;
      four_in      = four_ff;
      event_hit    = 1'b0;
      pix_hit      = 1'b0;
      argb         = 32'd0;
      px           = '0;
      py           = '0;
      err_code     = bmpdec_pkg::ERR_NONE;
      idx          = pos_ff;
      idx6         = '0;
      lane         = '0;
      bir_next     = '0;
      rows_next    = '0;

      if (accept) begin
         // a first byte restarts the file
         if (req_data.first_byte) begin
            phase_in = bmpdec_pkg::PH_HEADER;
            pos_in   = 32'd0;
            bir_in   = '0;
            x_in     = '0;
            k_in     = 2'd0;
            rows_in  = '0;
            img_w_in = '0;
            img_h_in = '0;
         end

         if (phase_in == bmpdec_pkg::PH_HEADER || phase_in == bmpdec_pkg::PH_SKIP ||
             phase_in == bmpdec_pkg::PH_PIXELS) begin
            // saturating byte position
            idx = pos_in;
            if (pos_in != 32'hFFFF_FFFF) begin
               pos_in = pos_in + 32'd1;
            end

            // header position and byte lane within its field
            idx6 = idx[5:0];
            lane = idx6[1:0] - 2'd2;

            if (phase_in == bmpdec_pkg::PH_HEADER) begin
               // capture header fields little-endian
               if (idx6 <= POS_SIG_END) begin
                  sig_in[{lane[0], 3'b000} +: 8] = req_data.data_byte;
               end else if (idx6 >= POS_OFF && idx6 < POS_INFO) begin
                  off_in[{lane, 3'b000} +: 8] = req_data.data_byte;
               end else if (idx6 >= POS_INFO && idx6 < POS_WIDTH) begin
                  info_in[{lane, 3'b000} +: 8] = req_data.data_byte;
               end else if (idx6 >= POS_WIDTH && idx6 < POS_HEIGHT) begin
                  wraw_in[{lane, 3'b000} +: 8] = req_data.data_byte;
               end else if (idx6 >= POS_HEIGHT && idx6 < POS_PLANES) begin
                  hraw_in[{lane, 3'b000} +: 8] = req_data.data_byte;
               end else if (idx6 >= POS_PLANES && idx6 < POS_BPP) begin
                  planes_in[{lane[0], 3'b000} +: 8] = req_data.data_byte;
               end else if (idx6 >= POS_BPP && idx6 < POS_COMP) begin
                  bpp_in[{lane[0], 3'b000} +: 8] = req_data.data_byte;
               end else if (idx6 >= POS_COMP && idx6 < POS_FIELD_END) begin
                  comp_in[{lane, 3'b000} +: 8] = req_data.data_byte;
               end

               // last header byte: run the checks
               if (idx6 == bmpdec_pkg::HDR_LAST_IDX) begin
                  if (hdr_err != bmpdec_pkg::ERR_NONE) begin
                     phase_in  = bmpdec_pkg::PH_ERROR;
                     err_code  = hdr_err;
                     event_hit = 1'b1;
                  end else begin
                     phase_in     = bmpdec_pkg::PH_SKIP;
                     img_w_in     = w_trunc;
                     img_h_in     = h_trunc;
                     pix_off_in   = off_ff;
                     bottom_in    = !hraw_ff[31];
                     four_in      = (bpp_ff == bmpdec_pkg::BPP_32);
                     row_total_in = row_calc;
                  end
               end
            end else begin
               // skip up to the pixel offset
               if (phase_in == bmpdec_pkg::PH_SKIP && idx >= pix_off_ff) begin
                  phase_in = bmpdec_pkg::PH_PIXELS;
               end

               if (phase_in == bmpdec_pkg::PH_PIXELS) begin
                  // pixel bytes of the row, padding falls through
                  if (x_in < img_w_ff) begin
                     case (k_in)
                        2'd0: begin
                           partial_in[7:0] = req_data.data_byte;
                        end
                        2'd1: begin
                           partial_in[15:8] = req_data.data_byte;
                        end
                        2'd2: begin
                           argb = {bmpdec_pkg::ALPHA_OPAQUE, req_data.data_byte,
                                   partial_ff[15:8], partial_ff[7:0]};
                           px        = x_in;
                           py        = bottom_ff ? (img_h_ff - HW'(1) - rows_in) : rows_in;
                           pix_hit   = 1'b1;
                           event_hit = 1'b1;
                        end
                        default: begin
                        end
                     endcase
                     if (k_in == k_last) begin
                        k_in = 2'd0;
                        x_in = x_in + WW'(1);
                     end else begin
                        k_in = k_in + 2'd1;
                     end
                  end

                  // row and image end
                  bir_next = {1'b0, bir_in} + (RW + 1)'(1);
                  if (bir_next >= {1'b0, row_total_ff}) begin
                     bir_in    = '0;
                     x_in      = '0;
                     k_in      = 2'd0;
                     rows_next = {1'b0, rows_in} + (HW + 1)'(1);
                     rows_in   = rows_next[HW-1:0];
                     if (rows_next >= {1'b0, img_h_ff}) begin
                        phase_in  = bmpdec_pkg::PH_DONE;
                        event_hit = 1'b1;
                     end
                  end else begin
                     bir_in = bir_next[RW-1:0];
                  end
               end
            end

            // early end of file
            if (req_data.last_byte && phase_in != bmpdec_pkg::PH_DONE &&
                phase_in != bmpdec_pkg::PH_ERROR) begin
               phase_in  = bmpdec_pkg::PH_ERROR;
               err_code  = bmpdec_pkg::ERR_TRUNC;
               event_hit = 1'b1;
            end
         end
      end
   end

   // result word
   assign px_ext = 32'(px);
   assign py_ext = 32'(py);
   assign w_ext  = 32'(img_w_in);
   assign h_ext  = 32'(img_h_in);

   always_comb begin
      rsp_data_in.has_pixel    = pix_hit;
      rsp_data_in.pixel_argb   = argb;
      rsp_data_in.pixel_x      = px_ext[11:0];
      rsp_data_in.pixel_y      = py_ext[11:0];
      rsp_data_in.image_width  = w_ext[12:0];
      rsp_data_in.image_height = h_ext[12:0];
      if (phase_in == bmpdec_pkg::PH_ERROR) begin
         rsp_data_in.outcome    = bmpdec_pkg::OUT_ERROR;
         rsp_data_in.error_code = err_code;
      end else if (phase_in == bmpdec_pkg::PH_DONE) begin
         rsp_data_in.outcome    = bmpdec_pkg::OUT_DONE;
         rsp_data_in.error_code = bmpdec_pkg::ERR_NONE;
      end else begin
         rsp_data_in.outcome    = bmpdec_pkg::OUT_BUSY;
         rsp_data_in.error_code = bmpdec_pkg::ERR_NONE;
      end
   end

   // output register holds until taken
   assign rsp_valid_in = (accept && event_hit) || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= bmpdec_pkg::PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      sig_ff       <= sig_in;
      off_ff       <= off_in;
      info_ff      <= info_in;
      wraw_ff      <= wraw_in;
      hraw_ff      <= hraw_in;
      planes_ff    <= planes_in;
      bpp_ff       <= bpp_in;
      comp_ff      <= comp_in;
      pix_off_ff   <= pix_off_in;
      img_w_ff     <= img_w_in;
      img_h_ff     <= img_h_in;
      row_total_ff <= row_total_in;
      bir_ff       <= bir_in;
      x_ff         <= x_in;
      k_ff         <= k_in;
      rows_ff      <= rows_in;
      partial_ff   <= partial_in;
      bottom_ff    <= bottom_in;
      four_ff      <= four_in;
      if (accept && event_hit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // checks
   assign chk_err_ok     = ((rsp_data_ff.outcome == bmpdec_pkg::OUT_ERROR) ==
                            (rsp_data_ff.error_code != bmpdec_pkg::ERR_NONE));
   assign chk_in_pix     = (phase_ff == bmpdec_pkg::PH_PIXELS);
   assign chk_col_ok     = (x_ff <= img_w_ff);
   assign chk_restart    = accept && req_data.first_byte;
   assign chk_hdr_or_err = (phase_ff == bmpdec_pkg::PH_HEADER) ||
                           (phase_ff == bmpdec_pkg::PH_ERROR);

   `BMPDEC_ASSERT_NOW(a_stall_full, clock, reset, req_stall, rsp_valid_ff, "stall while empty")
   `BMPDEC_ASSERT_NOW(a_err_code, clock, reset, rsp_valid_ff, chk_err_ok, "bad error code")
   `BMPDEC_ASSERT_NOW(a_col_range, clock, reset, chk_in_pix, chk_col_ok, "column past width")
   `BMPDEC_ASSERT_NEXT(a_first_restart, clock, reset, chk_restart, chk_hdr_or_err, "no restart")

endmodule
